// ----- design/acf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package acf_pkg;

  // Field widths of the channels.
  localparam int ACC_W      = 16;
  localparam int RATE_W     = 16;
  localparam int MS_W       = 10;
  localparam int ANG_W      = 17;
  localparam int W_W        = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Internal widths.
  localparam int G_W        = 17;  // rate minus offset
  localparam int PROD_W     = 26;  // |rate| * elapsed_ms
  localparam int NUM_W      = 28;  // reduced dividend
  localparam int RECIP_W    = 29;  // reciprocal of 125
  localparam int QP_W       = 57;  // dividend times reciprocal
  localparam int Q_W        = 21;  // useful quotient bits
  localparam int D_W        = 22;  // signed angle step
  localparam int CX_W       = 34;  // CORDIC x and y
  localparam int CZ_W       = 36;  // CORDIC angle, 24 fraction bits
  localparam int ACCANG_W   = 20;  // rounded accelerometer angle
  localparam int SUM_W      = 23;  // angle plus step
  localparam int P1_W       = 40;
  localparam int P2_W       = 38;
  localparam int BL_W       = 41;
  localparam int YT_W       = 24;  // biased yaw before wrapping
  localparam int CNT_W      = 5;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_IDX_W   = 4;
  localparam int WRAP_STEPS   = 5;

  // Rate step: q = floor((16*|g|*ms + 500) / 1000) = floor((2*|g|*ms + 62) / 125).
  // The division by 125 is a multiply by ceil(2^35 / 125) and a shift by 35, which
  // is exact for every dividend below 2^28.
  localparam int                 RECIP_SHIFT = 35;
  localparam logic [NUM_W-1:0]   NUM_BIAS    = 28'd62;
  localparam logic [RECIP_W-1:0] RECIP_M     = 29'd274877907;

  localparam int HALF_TURN   = 46080;
  localparam int FULL_TURN   = 92160;
  localparam int WRAP_OFFSET = 1520640;  // half turn plus sixteen full turns
  localparam logic signed [CZ_W-1:0] QUARTER_Z = 36'sd1509949440;
  localparam logic signed [CZ_W-1:0] ROUND_Z   = 36'sd32768;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFF_X   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFF_Y   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFF_Z   = 8'd3;
  localparam logic [W_W-1:0]       BLEND_RESET      = 16'd64225;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DINIT,
    ST_RUN,
    ST_MUL,
    ST_SUM,
    ST_WRAP,
    ST_COMMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  load;
    logic                  prep;
    logic                  div_init;
    logic                  cordic_step;
    logic [STEP_IDX_W-1:0] step_idx;
    logic                  mul;
    logic                  sum;
    logic                  wrap_step;
    logic [2:0]            wrap_k;
    logic                  commit;
    logic                  out_load;
  } ctrl_t;

  // atan(2^-i) in degrees with 24 fraction bits.
  function automatic logic signed [CZ_W-1:0] atan_entry(input logic [STEP_IDX_W-1:0] i);
    logic signed [CZ_W-1:0] v;
    case (i)
      4'd0:  v = 36'sd754974720;
      4'd1:  v = 36'sd445687602;
      4'd2:  v = 36'sd235489088;
      4'd3:  v = 36'sd119537938;
      4'd4:  v = 36'sd60000934;
      4'd5:  v = 36'sd30029717;
      4'd6:  v = 36'sd15018523;
      4'd7:  v = 36'sd7509720;
      4'd8:  v = 36'sd3754917;
      4'd9:  v = 36'sd1877466;
      4'd10: v = 36'sd938734;
      4'd11: v = 36'sd469367;
      4'd12: v = 36'sd234684;
      4'd13: v = 36'sd117342;
      4'd14: v = 36'sd58671;
      4'd15: v = 36'sd29335;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/acf_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sample channel.
interface acf_in_if;
  import acf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ACC_W-1:0]  accel_x;
  logic signed [ACC_W-1:0]  accel_y;
  logic signed [ACC_W-1:0]  accel_z;
  logic signed [RATE_W-1:0] rate_x;
  logic signed [RATE_W-1:0] rate_y;
  logic signed [RATE_W-1:0] rate_z;
  logic [MS_W-1:0]          elapsed_ms;
  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  elapsed_ms, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                elapsed_ms, output ready);
endinterface

// Attitude result channel.
interface acf_out_if;
  import acf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] roll_out;
  logic signed [ANG_W-1:0] pitch_out;
  logic signed [ANG_W-1:0] yaw_out;
  modport source (output valid, roll_out, pitch_out, yaw_out, input ready);
  modport sink (input valid, roll_out, pitch_out, yaw_out, output ready);
endinterface

// Register write channel.
interface acf_cfg_if;
  import acf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/acf_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
module acf_cordic (
  input  wire logic                             clk,
  input  wire logic                             init,
  input  wire logic                             step,
  input  wire logic [acf_pkg::STEP_IDX_W-1:0]   idx,
  input  wire logic signed [acf_pkg::ACC_W-1:0] y_in,
  input  wire logic signed [acf_pkg::ACC_W-1:0] x_in,
  output logic signed [acf_pkg::ACCANG_W-1:0]   angle
);
  import acf_pkg::*;

  logic signed [CX_W-1:0] x_r, y_r;
  logic signed [CZ_W-1:0] z_r;
  logic                   zero_r;
  logic signed [CX_W-1:0] xs, ys, xsh, ysh;
  logic signed [CZ_W-1:0] zr;

  // Operands scaled by 2^14.
  assign xs = {{(CX_W-ACC_W-14){x_in[ACC_W-1]}}, x_in, 14'b0};
  assign ys = {{(CX_W-ACC_W-14){y_in[ACC_W-1]}}, y_in, 14'b0};
  assign xsh = x_r >>> idx;
  assign ysh = y_r >>> idx;

  // Pre-rotation on load, then one micro-rotation per step.
  always_ff @(posedge clk) begin
    if (init) begin
      zero_r <= (x_in == '0) && (y_in == '0);
      if (xs[CX_W-1]) begin
        if (!ys[CX_W-1]) begin
          x_r <= ys;
          y_r <= -xs;
          z_r <= QUARTER_Z;
        end else begin
          x_r <= -ys;
          y_r <= xs;
          z_r <= -QUARTER_Z;
        end
      end else begin
        x_r <= xs;
        y_r <= ys;
        z_r <= '0;
      end
    end else if (step) begin
      if (!y_r[CX_W-1]) begin
        x_r <= x_r + ysh;
        y_r <= y_r - xsh;
        z_r <= z_r + atan_entry(idx);
      end else begin
        x_r <= x_r - ysh;
        y_r <= y_r + xsh;
        z_r <= z_r - atan_entry(idx);
      end
    end
  end

  // Round to 8 fraction bits; both operands zero gives zero.
  assign zr = z_r + ROUND_Z;
  assign angle = zero_r ? '0 : zr[CZ_W-1:16];

endmodule
`default_nettype wire

// ----- design/acf_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module acf_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire acf_pkg::ctrl_t                      ctrl,
  input  wire logic signed [acf_pkg::ACC_W-1:0]    accel_x,
  input  wire logic signed [acf_pkg::ACC_W-1:0]    accel_y,
  input  wire logic signed [acf_pkg::ACC_W-1:0]    accel_z,
  input  wire logic signed [acf_pkg::RATE_W-1:0]   rate_x,
  input  wire logic signed [acf_pkg::RATE_W-1:0]   rate_y,
  input  wire logic signed [acf_pkg::RATE_W-1:0]   rate_z,
  input  wire logic [acf_pkg::MS_W-1:0]            elapsed_ms,
  input  wire logic                                cfg_we,
  input  wire logic [acf_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [acf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic signed [acf_pkg::ANG_W-1:0]         roll_out,
  output logic signed [acf_pkg::ANG_W-1:0]         pitch_out,
  output logic signed [acf_pkg::ANG_W-1:0]         yaw_out
);
  import acf_pkg::*;

  logic [W_W-1:0]              w_r;
  logic signed [RATE_W-1:0]    off_r [3];
  logic signed [ACC_W-1:0]     ax_r, ay_r, az_r;
  logic signed [G_W-1:0]       g_r [3];
  logic                        neg_r [3];
  logic [MS_W-1:0]             ms_r;
  logic [PROD_W-1:0]           prod_r [3];
  logic [Q_W-1:0]              q_r [3];
  logic signed [P1_W-1:0]      p1_r [2];
  logic signed [P2_W-1:0]      p2_r [2];
  logic [YT_W-1:0]             yt_r;
  logic signed [ANG_W-1:0]     roll_r, pitch_r, yaw_r;
  logic signed [ANG_W-1:0]     out_roll_r, out_pitch_r, out_yaw_r;

  logic signed [RATE_W-1:0]    rate_in [3];
  logic signed [G_W-1:0]       g_abs [3];
  logic [NUM_W-1:0]            num [3];
  logic [QP_W-1:0]             qp [3];
  logic signed [D_W-1:0]       d [3];
  logic signed [ACCANG_W-1:0]  acc_roll, acc_pitch_raw, acc [2];
  logic signed [ANG_W-1:0]     ang [2];
  logic signed [SUM_W-1:0]     bsum [2];
  logic [W_W:0]                aw;
  logic [YT_W-1:0]             wrap_lim;

  assign rate_in[0] = rate_x;
  assign rate_in[1] = rate_y;
  assign rate_in[2] = rate_z;

  // Register file for alpha and the gyro offsets; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r      <= BLEND_RESET;
      off_r[0] <= '0;
      off_r[1] <= '0;
      off_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BLEND_WEIGHT: w_r      <= cfg_data;
        REG_GYRO_OFF_X:   off_r[0] <= cfg_data;
        REG_GYRO_OFF_Y:   off_r[1] <= cfg_data;
        REG_GYRO_OFF_Z:   off_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accelerometer angles from two CORDIC lanes sharing the z operand.
  acf_cordic u_cordic_roll (
    .clk(clk), .init(ctrl.prep), .step(ctrl.cordic_step), .idx(ctrl.step_idx),
    .y_in(ay_r), .x_in(az_r), .angle(acc_roll)
  );
  acf_cordic u_cordic_pitch (
    .clk(clk), .init(ctrl.prep), .step(ctrl.cordic_step), .idx(ctrl.step_idx),
    .y_in(ax_r), .x_in(az_r), .angle(acc_pitch_raw)
  );
  assign acc[0] = acc_roll;
  assign acc[1] = -acc_pitch_raw;

  // Rounded division by 1000 as a reciprocal multiply, then the signed angle steps.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      g_abs[k] = g_r[k][G_W-1] ? -g_r[k] : g_r[k];
      num[k]   = {prod_r[k], 1'b0} + NUM_BIAS;
      qp[k]    = QP_W'(num[k]) * QP_W'(RECIP_M);
      d[k] = neg_r[k] ? -$signed({1'b0, q_r[k]})
                      : $signed({1'b0, q_r[k]});
    end
  end

  // Blend operands.
  assign ang[0] = roll_r;
  assign ang[1] = pitch_r;
  assign aw = (W_W+1)'(1 << W_W) - {1'b0, w_r};
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      bsum[k] = SUM_W'(ang[k]) + SUM_W'(d[k]);
    end
  end
  assign wrap_lim = YT_W'(FULL_TURN) << ctrl.wrap_k;

  // Sample capture, rate products, quotients, the blend products and the yaw wrap.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ax_r <= accel_x;
      ay_r <= accel_y;
      az_r <= accel_z;
      ms_r <= elapsed_ms;
      for (int k = 0; k < 3; k++) begin
        g_r[k] <= G_W'(rate_in[k]) - G_W'(off_r[k]);
      end
    end
    if (ctrl.prep) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PROD_W'(g_abs[k][RATE_W-1:0]) * PROD_W'(ms_r);
        neg_r[k]  <= g_r[k][G_W-1];
      end
    end
    if (ctrl.div_init) begin
      for (int k = 0; k < 3; k++) begin
        q_r[k] <= qp[k][RECIP_SHIFT +: Q_W];
      end
    end
    if (ctrl.mul) begin
      for (int k = 0; k < 2; k++) begin
        p1_r[k] <= $signed({1'b0, w_r}) * bsum[k];
        p2_r[k] <= $signed({1'b0, aw}) * acc[k];
      end
      yt_r <= YT_W'(YT_W'(yaw_r) + YT_W'(d[2]) + YT_W'(WRAP_OFFSET));
    end else if (ctrl.wrap_step) begin
      if (yt_r >= wrap_lim) begin
        yt_r <= yt_r - wrap_lim;
      end
    end
  end

  // Blend sum, rounding and saturation; yaw commit after wrapping.
  logic signed [BL_W-1:0]     bl [2];
  logic signed [BL_W-16-1:0]  bv [2];
  logic signed [ANG_W-1:0]    sat [2];
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      bl[k] = BL_W'(p1_r[k]) + BL_W'(p2_r[k]) + BL_W'(32768);
      bv[k] = bl[k][BL_W-1:16];
      if (bv[k] > (BL_W-16)'(HALF_TURN)) begin
        sat[k] = ANG_W'(HALF_TURN);
      end else if (bv[k] < -(BL_W-16)'(HALF_TURN)) begin
        sat[k] = -ANG_W'(HALF_TURN);
      end else begin
        sat[k] = bv[k][ANG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
    end else begin
      if (ctrl.sum) begin
        roll_r  <= sat[0];
        pitch_r <= sat[1];
      end
      if (ctrl.commit) begin
        yaw_r <= ANG_W'(yt_r - YT_W'(HALF_TURN));
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_roll_r  <= roll_r;
      out_pitch_r <= pitch_r;
      out_yaw_r   <= yaw_r;
    end
  end

  assign roll_out  = out_roll_r;
  assign pitch_out = out_pitch_r;
  assign yaw_out   = out_yaw_r;

endmodule
`default_nettype wire

// ----- design/acf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module acf_ctrl (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    out_ready,
  output logic         in_ready,
  output logic         out_valid,
  output acf_pkg::ctrl_t ctrl
);
  import acf_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_DINIT;
      ST_DINIT:  state_nxt = ST_RUN;
      ST_RUN:    if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_WRAP;
      ST_WRAP:   if (cnt_r == CNT_W'(WRAP_STEPS - 1)) state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Step counter restarts on every state change.
  assign cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;

  // Commands to the datapath.
  always_comb begin
    ctrl = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      ST_PREP:  ctrl.prep = 1'b1;
      ST_DINIT: ctrl.div_init = 1'b1;
      ST_RUN: begin
        ctrl.cordic_step = 1'b1;
        ctrl.step_idx    = cnt_r[STEP_IDX_W-1:0];
      end
      ST_MUL: ctrl.mul = 1'b1;
      ST_SUM: ctrl.sum = 1'b1;
      ST_WRAP: begin
        ctrl.wrap_step = 1'b1;
        ctrl.wrap_k    = 3'(CNT_W'(WRAP_STEPS - 1) - cnt_r);
      end
      ST_COMMIT: ctrl.commit = 1'b1;
      ST_DONE:   ctrl.out_load = out_free;
      default: ;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (ctrl.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- design/imu_complementary_attitude_filter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Complementary attitude filter: each accepted IMU sample yields one fused roll,
// pitch and yaw result in 1/256 degree. After acceptance a sample goes through
// the rate products, the reciprocal multiply that divides them by 1000, the
// micro-rotations of the two CORDIC lanes, the blend multiply and sum, the yaw
// wrap steps, the yaw commit and the load of the result. One sample is in work at
// a time, so a new sample is taken only once the last result is loaded; it is
// taken while a finished result still waits on the output, and a second
// finished result holds the block until the first is taken. Registers (index:
// 0 alpha Q0.16, 1..3 gyro offsets x/y/z) are always ready and should be written
// only while the block is idle.
module imu_complementary_attitude_filter_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  acf_in_if.sink    in_ch,
  acf_out_if.source out_ch,
  acf_cfg_if.sink   cfg_ch
);
  import acf_pkg::*;

  ctrl_t ctrl;
  logic  in_ready;
  logic  out_valid;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // Sequencer.
  acf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .out_ready(out_ch.ready),
    .in_ready(in_ready), .out_valid(out_valid), .ctrl(ctrl)
  );

  // Arithmetic and state.
  acf_datapath u_datapath (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
    .accel_x(in_ch.accel_x), .accel_y(in_ch.accel_y), .accel_z(in_ch.accel_z),
    .rate_x(in_ch.rate_x), .rate_y(in_ch.rate_y), .rate_z(in_ch.rate_z),
    .elapsed_ms(in_ch.elapsed_ms),
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_data(cfg_ch.data),
    .roll_out(out_ch.roll_out), .pitch_out(out_ch.pitch_out), .yaw_out(out_ch.yaw_out)
  );

endmodule
`default_nettype wire
